// ===== src/acd_pkg.sv =====
package acd_pkg;

  localparam int STATE_W           = 10;
  localparam int SYM_W             = 8;
  localparam int POS_W             = 17;
  localparam int SYMBOLS           = 256;
  localparam int STATE_COUNT_DEF   = 1024;
  localparam int BUFFER_LENGTH_DEF = 64 * 1024;
  localparam int POS_FIELD_MAX     = 131071;

  typedef enum logic [1:0] {
    ACT_WRITE_TRANS = 2'd0,
    ACT_WRITE_MARK  = 2'd1,
    ACT_SCAN        = 2'd2,
    ACT_SET_STATE   = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [STATE_W-1:0]   table_state;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   next_state;
    logic                 match_mark;
    logic                 buffer_start;
  } in_item_t;

  typedef struct packed {
    logic                 match_found;
    logic [STATE_W-1:0]   dfa_state;
    logic [POS_W-1:0]     position;
  } out_item_t;

  // Write and read request towards the match mark store.
  typedef struct packed {
    logic                 wr_en;
    logic [STATE_W-1:0]   wr_state;
    logic                 wr_mark;
    logic                 rd_en;
    logic [STATE_W-1:0]   rd_state;
  } mark_req_t;

  // Fold 'a'..'z' to 'A'..'Z'; pass every other byte unchanged.
  function automatic logic [SYM_W-1:0] fold_upper(input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] r;
    r = b;
    if (b inside {[8'h61:8'h7A]}) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== src/acd_trans_mem.sv =====
module acd_trans_mem import acd_pkg::*; #(
  parameter int STATES = STATE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(STATES)+SYM_W-1:0]      wr_addr,
  input  logic [$clog2(STATES)-1:0]            wr_data,
  input  logic                                 rd_en,
  input  logic [$clog2(STATES)+SYM_W-1:0]      rd_addr,
  output logic [$clog2(STATES)-1:0]            rd_data
);

  localparam int SW    = $clog2(STATES);
  localparam int DEPTH = STATES * SYMBOLS;

  logic [SW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/acd_mark_mem.sv =====
module acd_mark_mem import acd_pkg::*; #(
  parameter int STATES = STATE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  mark_req_t req,
  output logic      rd_mark,
  output logic      busy
);

  localparam int SW = $clog2(STATES);

  logic          mem [STATES];
  logic [SW-1:0] clr_idx;

  // Sweep every entry to zero after reset, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == SW'(STATES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= 1'b0;
    end else if (req.wr_en) begin
      mem[req.wr_state[SW-1:0]] <= req.wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_mark <= mem[req.rd_state[SW-1:0]];
    end
  end

endmodule

// ===== src/aho_corasick_dfa_scanner.sv =====
// A scan item passes through the transition lookup, then the match mark read, then the output register.
// A new scan item waits until the lookup of the one before it returns, as the transition lookup loop
// (state -> memory read -> state) needs that state. Table writes and set-state items give no result.
// Reset: synchronous; state to root, position to zero, then the match mark store sweeps all
// min(STATE_COUNT, 1024) entries to zero, during which input is stalled.
module aho_corasick_dfa_scanner import acd_pkg::*; #(
  parameter int STATE_COUNT   = STATE_COUNT_DEF,
  parameter int BUFFER_LENGTH = BUFFER_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // States the 10-bit fields can name at all.
  localparam int EFF     = (STATE_COUNT < (1 << STATE_W)) ? STATE_COUNT : (1 << STATE_W);
  localparam int SW      = $clog2(EFF);
  localparam int AW      = SW + SYM_W;
  localparam int POS_CAP = (BUFFER_LENGTH < POS_FIELD_MAX) ? BUFFER_LENGTH : POS_FIELD_MAX;

  logic             accept;
  logic             clr_busy;
  logic             tstate_ok;
  logic             nstate_ok;

  logic [SW-1:0]    scan_state;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;

  // Lookup stage: transition read in flight.
  logic             b_valid;
  logic [POS_W-1:0] b_pos;
  logic             b_adv;
  logic [SW-1:0]    tr_q;
  logic [SW-1:0]    tr_next;

  // Mark stage: mark read in flight.
  logic             c_valid;
  logic [SW-1:0]    c_state;
  logic [POS_W-1:0] c_pos;
  logic             c_move;
  logic             mark_q;

  mark_req_t        mreq;

  // Hold input while the mark store is swept or a lookup is in flight: the next
  // scan needs the state that the lookup returns.
  assign in_stall = clr_busy || b_valid;
  assign accept   = in_valid && !in_stall;

  // Drop writes and set-state requests that name a state beyond the table.
  assign tstate_ok = {1'b0, in_item.table_state} < (STATE_W + 1)'(EFF);
  assign nstate_ok = {1'b0, in_item.next_state}  < (STATE_W + 1)'(EFF);

  // Restart the count on buffer_start, otherwise advance and saturate.
  always_comb begin
    byte_position_next = byte_position;
    if (in_item.buffer_start) begin
      byte_position_next = POS_W'(1);
    end else if (byte_position < POS_W'(POS_CAP)) begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  acd_trans_mem #(
    .STATES (EFF)
  ) u_trans (
    .clk     (clk),
    .wr_en   (accept && in_item.action == ACT_WRITE_TRANS && tstate_ok && nstate_ok),
    .wr_addr ({in_item.table_state[SW-1:0], in_item.symbol}),
    .wr_data (in_item.next_state[SW-1:0]),
    .rd_en   (accept && in_item.action == ACT_SCAN),
    .rd_addr (AW'({scan_state, fold_upper(in_item.symbol)})),
    .rd_data (tr_q)
  );

  // An entry never written may hold anything; keep the state inside the table.
  assign tr_next = ({1'b0, tr_q} < (SW + 1)'(EFF)) ? tr_q : '0;

  assign c_move = c_valid && (!out_valid || !out_stall);
  assign b_adv  = b_valid && (!c_valid || c_move);

  always_comb begin
    mreq          = '0;
    mreq.wr_en    = accept && in_item.action == ACT_WRITE_MARK && tstate_ok;
    mreq.wr_state = in_item.table_state;
    mreq.wr_mark  = in_item.match_mark;
    mreq.rd_en    = b_adv;
    mreq.rd_state = STATE_W'(tr_next);
  end

  acd_mark_mem #(
    .STATES (EFF)
  ) u_mark (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_mark (mark_q),
    .busy    (clr_busy)
  );

  // Scan state and position. Set-state can never meet a lookup update, since
  // input is held while a lookup is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= '0;
      byte_position <= '0;
    end else begin
      if (accept && in_item.action == ACT_SCAN) begin
        byte_position <= byte_position_next;
      end
      if (accept && in_item.action == ACT_SET_STATE && tstate_ok) begin
        scan_state <= in_item.table_state[SW-1:0];
      end else if (b_adv) begin
        scan_state <= tr_next;
      end
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && in_item.action == ACT_SCAN) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end

      if (b_adv) begin
        c_valid <= 1'b1;
      end else if (c_move) begin
        c_valid <= 1'b0;
      end

      if (c_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && in_item.action == ACT_SCAN) begin
      b_pos <= byte_position_next;
    end
    if (b_adv) begin
      c_state <= tr_next;
      c_pos   <= b_pos;
    end
    if (c_move) begin
      out_item.match_found <= mark_q;
      out_item.dfa_state   <= STATE_W'(c_state);
      out_item.position    <= c_pos;
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acd_pkg::*;

  // Stop when neither side has moved an item for this many cycles. The
  // mark sweep after reset is the longest quiet spell.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 730;
  localparam int TAIL_ITEMS     = 150;
  localparam int POS_CAP        = (BUFFER_LENGTH_DEF < POS_FIELD_MAX) ?
                                  BUFFER_LENGTH_DEF : POS_FIELD_MAX;

  // Predicts the scanner: owns a copy of the loaded automaton, the scan
  // state and the byte position, and queues one expected result per scan.
  class scan_scoreboard;
    bit [STATE_W-1:0] trans_tbl [bit [STATE_W+SYM_W-1:0]];
    bit [SYMBOLS-1:0] row_map [STATE_COUNT_DEF];   // entries written so far
    bit               mark_tbl [STATE_COUNT_DEF];
    bit [STATE_W-1:0] scan_state;
    bit [POS_W-1:0]   byte_pos;
    out_item_t        expected_q [$];
    int               errors;

    function void note_input(in_item_t it);
      bit [SYM_W-1:0]         col;
      bit [STATE_W+SYM_W-1:0] key;
      out_item_t              exp_item;
      case (it.action)
        ACT_WRITE_TRANS: begin
          if (it.table_state < STATE_COUNT_DEF && it.next_state < STATE_COUNT_DEF) begin
            trans_tbl[{it.table_state, it.symbol}] = it.next_state;
            row_map[it.table_state][it.symbol] = 1'b1;
          end
        end
        ACT_WRITE_MARK: begin
          if (it.table_state < STATE_COUNT_DEF) mark_tbl[it.table_state] = it.match_mark;
        end
        ACT_SET_STATE: begin
          // position is left alone
          if (it.table_state < STATE_COUNT_DEF) scan_state = it.table_state;
        end
        default: begin
          col = it.symbol;
          if (col >= 8'h61 && col <= 8'h7A) col = col - 8'h20;
          key = {scan_state, col};
          scan_state = trans_tbl.exists(key) ? trans_tbl[key] : '0;
          if (it.buffer_start) byte_pos = POS_W'(1);
          else if (byte_pos < POS_CAP) byte_pos = byte_pos + 1'b1;
          exp_item.match_found = mark_tbl[scan_state];
          exp_item.dfa_state   = scan_state;
          exp_item.position    = byte_pos;
          expected_q = {expected_q, exp_item};
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $error("result with none expected: state %0d position %0d",
               got.dfa_state, got.position);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.match_found !== exp_item.match_found) begin
        $error("match_found: expected %0d, got %0d", exp_item.match_found, got.match_found);
        errors++;
      end
      if (got.dfa_state !== exp_item.dfa_state) begin
        $error("dfa_state: expected %0d, got %0d",
               exp_item.dfa_state, got.dfa_state);
        errors++;
      end
      if (got.position !== exp_item.position) begin
        $error("position: expected %0d, got %0d", exp_item.position, got.position);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  scan_scoreboard   sb;
  bit               idling;          // random gaps and stalls allowed
  int               items_sent;
  int               idle_cycles;
  int               stall_left;
  bit [STATE_W-1:0] live_states [$]; // states of the automaton loaded last

  aho_corasick_dfa_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result side in bursts of random length while idling is on.
  always @(negedge clk) begin
    if (idling && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every accepted result and count cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit is_lower(bit [SYM_W-1:0] b);
    return b >= 8'h61 && b <= 8'h7A;
  endfunction

  // Fully random item: don't-care fields get random bits too.
  function automatic in_item_t random_item();
    return in_item_t'($urandom);
  endfunction

  // Pick a written column that a scan byte can reach from state s
  // (lower-case columns fold away, so skip them); -1 if there is none.
  function automatic int usable_column(bit [STATE_W-1:0] s);
    int start;
    int c;
    start = $urandom_range(0, SYMBOLS - 1);
    for (int i = 0; i < SYMBOLS; i++) begin
      c = (start + i) % SYMBOLS;
      if (sb.row_map[s][c] && !is_lower(c[SYM_W-1:0])) return c;
    end
    return -1;
  endfunction

  // Present one item from a falling edge, hold it until accepted, then note
  // it in the predictor. Returns at the next falling edge.
  task automatic send_item(in_item_t it);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put(action_t a, int ts, int sym, int ns, bit mk, bit bs);
    in_item_t it;
    it.action       = a;
    it.table_state  = STATE_W'(ts);
    it.symbol       = SYM_W'(sym);
    it.next_state   = STATE_W'(ns);
    it.match_mark   = mk;
    it.buffer_start = bs;
    send_item(it);
  endtask

  // Scan one byte that hits a written entry. If the current state has no
  // usable row, jump back into the loaded automaton first.
  task automatic scan_byte(bit bs);
    in_item_t it;
    int       c;
    c = usable_column(sb.scan_state);
    if (c < 0) begin
      it = random_item();
      it.action      = ACT_SET_STATE;
      it.table_state = live_states[$urandom_range(0, live_states.size() - 1)];
      send_item(it);
      c = usable_column(sb.scan_state);
    end
    it = random_item();
    it.action       = ACT_SCAN;
    it.symbol       = c[SYM_W-1:0];
    it.buffer_start = bs;
    // upper-case column: half the time feed the lower-case byte instead
    if (c >= 'h41 && c <= 'h5A && $urandom_range(0, 1) == 1) it.symbol = SYM_W'(c + 'h20);
    send_item(it);
  endtask

  task automatic scan_burst(int len);
    for (int i = 0; i < len; i++) begin
      scan_byte(i == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0));
    end
  endtask

  // Load a small closed automaton: every state gets at least one reachable
  // column, and every target stays inside the set.
  task automatic load_automaton();
    in_item_t it;
    int       n;
    live_states.delete();
    n = $urandom_range(2, 8);
    repeat (n) live_states = {live_states, STATE_W'($urandom)};
    if ($urandom_range(0, 3) == 0) live_states[0] = '0;
    if ($urandom_range(0, 3) == 0) live_states[1] = '1;
    foreach (live_states[i]) begin
      for (int k = $urandom_range(1, 6); k > 0; k--) begin
        it = random_item();
        it.action      = ACT_WRITE_TRANS;
        it.table_state = live_states[i];
        it.next_state  = live_states[$urandom_range(0, n - 1)];
        if (k == 1 && is_lower(it.symbol)) it.symbol = it.symbol - 8'h20;
        send_item(it);
      end
      it = random_item();
      it.action      = ACT_WRITE_MARK;
      it.table_state = live_states[i];
      send_item(it);
    end
  endtask

  // Noise: random table writes, mark writes and jumps to arbitrary states.
  task automatic send_noise();
    in_item_t it;
    it = random_item();
    if (it.action == ACT_SCAN) it.action = ACT_SET_STATE;
    send_item(it);
  endtask

  initial begin
    int target;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    stall_left = 0;
    idling     = 1'b1;
    items_sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: field extremes and the corner cases of the scanner.
    put(ACT_WRITE_TRANS, 0, 'h41, 1023, 0, 0);
    put(ACT_WRITE_TRANS, 1023, 'hFF, 0, 0, 0);
    put(ACT_WRITE_TRANS, 0, 'h00, 0, 0, 0);
    put(ACT_WRITE_TRANS, 1023, 'h5A, 1023, 0, 0);
    put(ACT_WRITE_TRANS, 0, 'h7B, 0, 0, 0);
    put(ACT_WRITE_TRANS, 0, 'h60, 1023, 0, 0);
    put(ACT_WRITE_MARK, 1023, 0, 0, 1, 0);
    put(ACT_WRITE_MARK, 0, 0, 0, 0, 0);
    // first byte after reset without buffer_start, and lower case folding
    put(ACT_SCAN, 0, 'h61, 0, 0, 0);
    put(ACT_SCAN, 0, 'h7A, 0, 0, 0);
    // new buffer, then a second buffer start straight after
    put(ACT_SCAN, 0, 'hFF, 0, 0, 1);
    put(ACT_SCAN, 0, 'h00, 0, 0, 1);
    // bytes just outside the folded range pass unchanged
    put(ACT_SCAN, 0, 'h60, 0, 0, 0);
    // set state keeps the position running
    put(ACT_SET_STATE, 0, 0, 0, 0, 0);
    put(ACT_SCAN, 0, 'h7B, 0, 0, 0);
    put(ACT_SCAN, 0, 'h41, 0, 0, 0);
    // clear a mark, overwrite an entry
    put(ACT_WRITE_MARK, 1023, 0, 0, 0, 0);
    put(ACT_SCAN, 0, 'h5A, 0, 0, 0);
    put(ACT_WRITE_TRANS, 1023, 'hFF, 1023, 0, 0);
    put(ACT_SCAN, 0, 'hFF, 0, 0, 0);
    // all-ones item on a set-state
    put(ACT_SET_STATE, 1023, 'hFF, 1023, 1, 1);
    put(ACT_SCAN, 1023, 'h7A, 1023, 1, 1);
    live_states = {live_states, STATE_W'(0)};
    live_states = {live_states, STATE_W'(1023)};

    // Random part: mostly loaded automata scanned with well-formed bytes,
    // with noise and stray jumps mixed in.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1:    load_automaton();
        8, 9:    repeat ($urandom_range(1, 4)) send_noise();
        default: scan_burst($urandom_range(8, 40));
      endcase
    end

    // Tail: no gaps and no stalls.
    idling = 1'b0;
    target = items_sent + TAIL_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      else scan_burst($urandom_range(4, 20));
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray result.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/acd_pkg.sv
src/acd_trans_mem.sv
src/acd_mark_mem.sv
src/aho_corasick_dfa_scanner.sv
tb/tb.sv
